// File: design/ccx_pkg.sv
`default_nettype none

package ccx_pkg;

    // Block constants
    localparam logic [31:0] Sigma0       = 32'h6170_7865;
    localparam logic [31:0] Sigma1       = 32'h3320_646e;
    localparam logic [31:0] Sigma2       = 32'h7962_2d32;
    localparam logic [31:0] Sigma3       = 32'h6b20_6574;
    localparam logic [31:0] CounterStart = 32'h0000_1000;
    localparam logic [31:0] NonceTweak1  = 32'h1234_5678;
    localparam logic [31:0] NonceTweak2  = 32'h2468_acf0;
    localparam int          NonceBytes   = 12;

    // Sequencer: 20 half-rounds x 4 quarter-rounds x 4 add/xor/rotate steps
    localparam int         RoundSteps    = 320;
    localparam logic [8:0] LastRoundStep = 9'(RoundSteps - 1);
    localparam logic [8:0] LastFinalStep = 9'd15;

    // Register indexes (paddr[5:3])
    localparam logic [2:0] RegKeyA   = 3'd0;
    localparam logic [2:0] RegKeyB   = 3'd1;
    localparam logic [2:0] RegKeyC   = 3'd2;
    localparam logic [2:0] RegKeyD   = 3'd3;
    localparam logic [2:0] RegNonceL = 3'd4;
    localparam logic [2:0] RegNonceH = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINAL,
        ST_EMIT
    } t_fsm_e;

    typedef logic [31:0] t_words [16];

    function automatic logic [31:0] ccx_rotl(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    // Block input words for the current key, nonce and counter
    function automatic t_words ccx_init_words(
        input logic [63:0] key_a,
        input logic [63:0] key_b,
        input logic [63:0] key_c,
        input logic [63:0] key_d,
        input logic [63:0] nonce_l,
        input logic [31:0] nonce_h,
        input logic [31:0] counter
    );
        t_words       w;
        logic [255:0] key;
        logic [95:0]  nonce;
        logic [7:0]   kb;
        logic [15:0]  dbl;
        int           i;
        key   = {key_d, key_c, key_b, key_a};
        nonce = {nonce_h, nonce_l};
        w[0]  = Sigma0;
        w[1]  = Sigma1;
        w[2]  = Sigma2;
        w[3]  = Sigma3;
        for (i = 4; i < 12; i++) begin
            w[i] = '0;
        end
        // key byte XOR nonce byte, then rotate within the byte
        for (i = 0; i < 32; i++) begin
            kb  = key[8*i +: 8] ^ nonce[8*(i % NonceBytes) +: 8];
            dbl = {kb, kb} << (i % 8);
            w[4 + i/4][8*(i % 4) +: 8] = dbl[15:8];
        end
        w[12] = counter;
        w[13] = nonce[31:0];
        w[14] = nonce[63:32] ^ NonceTweak1;
        w[15] = nonce[95:64] ^ NonceTweak2;
        return w;
    endfunction

    // Every row rotated left by one column
    function automatic t_words ccx_col_shift(input t_words s);
        t_words o;
        int     r;
        int     j;
        for (r = 0; r < 4; r++) begin
            for (j = 0; j < 4; j++) begin
                o[4*r + j] = s[4*r + (j + 1) % 4];
            end
        end
        return o;
    endfunction

    // Row r rotated left by r: diagonals line up as columns
    function automatic t_words ccx_diag(input t_words s);
        t_words o;
        int     r;
        int     j;
        for (r = 0; r < 4; r++) begin
            for (j = 0; j < 4; j++) begin
                o[4*r + j] = s[4*r + (j + r) % 4];
            end
        end
        return o;
    endfunction

    // Inverse of ccx_diag
    function automatic t_words ccx_undiag(input t_words s);
        t_words o;
        int     r;
        int     j;
        for (r = 0; r < 4; r++) begin
            for (j = 0; j < 4; j++) begin
                o[4*r + j] = s[4*r + (j + 4 - r) % 4];
            end
        end
        return o;
    endfunction

endpackage

`default_nettype wire

// File: design/chacha20_keystream_xor_variant_unit.sv
`default_nettype none

// Channel   Dir   Handshake                      Payload
// s_axis    in    s_axis_tvalid/s_axis_tready     tdata = in_byte, tlast = last_in
// m_axis    out   m_axis_tvalid/m_axis_tready     tdata = out_byte, tlast = last_out
// apb       in    psel/penable (pready high)      6 registers at 8*i (5 x 64-bit, 1 x 32-bit)
//
// A byte within a ready keystream block is accepted, then emitted.
// A byte that starts a block first has one generated: one 32-bit adder with an
// xor/rotate does one quarter-round step per cycle (320 steps), then the same
// adder adds the input words back, one word per cycle (16 steps).
// Reset is synchronous; the keystream store has no reset and is always
// regenerated before it is read. The output register holds while m_axis
// stalls; the block is not ready while a byte is being worked on.

module chacha20_keystream_xor_variant_unit
    import ccx_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  wire         s_axis_tlast,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [5:0]  paddr,
    input  wire  [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    t_fsm_e      r_state, n_state;
    logic [8:0]  r_step, n_step;
    logic [5:0]  r_pos, n_pos;
    logic [31:0] r_counter, n_counter;
    logic        r_block_ready, n_block_ready;
    logic        r_m_valid, n_m_valid;
    logic [7:0]  r_m_data, n_m_data;
    logic        r_m_last, n_m_last;
    logic [7:0]  r_hold_byte, n_hold_byte;
    logic        r_hold_last, n_hold_last;
    t_words      r_words, n_words;

    logic [63:0] r_key_a, r_key_b, r_key_c, r_key_d, r_nonce_l;
    logic [31:0] r_nonce_h;

    t_words      w_init;
    t_words      w_qr;
    t_words      w_col;
    t_words      w_round_next;
    t_words      w_fin_next;
    logic [31:0] w_op_a, w_op_b, w_sum;
    logic [31:0] w_ks_word;
    logic [31:0] w_ks_shift;
    logic        w_in_fire;
    logic        w_emit_fire;
    logic        w_cfg_wr;

    assign pready        = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;

    assign w_in_fire   = s_axis_tvalid && s_axis_tready;
    assign w_emit_fire = (r_state == ST_EMIT) && (!r_m_valid || m_axis_tready);
    assign w_cfg_wr    = psel && penable && pwrite && pready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_a   <= '0;
            r_key_b   <= '0;
            r_key_c   <= '0;
            r_key_d   <= '0;
            r_nonce_l <= '0;
            r_nonce_h <= '0;
        end else if (w_cfg_wr) begin
            case (paddr[5:3])
                RegKeyA:   r_key_a   <= pwdata;
                RegKeyB:   r_key_b   <= pwdata;
                RegKeyC:   r_key_c   <= pwdata;
                RegKeyD:   r_key_d   <= pwdata;
                RegNonceL: r_nonce_l <= pwdata;
                RegNonceH: r_nonce_h <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (paddr[5:3])
            RegKeyA:   prdata = r_key_a;
            RegKeyB:   prdata = r_key_b;
            RegKeyC:   prdata = r_key_c;
            RegKeyD:   prdata = r_key_d;
            RegNonceL: prdata = r_nonce_l;
            RegNonceH: prdata = {32'd0, r_nonce_h};
            default:   prdata = '0;
        endcase
    end

    assign w_init = ccx_init_words(r_key_a, r_key_b, r_key_c, r_key_d,
                                   r_nonce_l, r_nonce_h, r_counter);

    // Shared adder operand select
    always_comb begin
        case (r_state)
            ST_FINAL: begin
                w_op_a = r_words[0];
                w_op_b = w_init[r_step[3:0]];
            end
            default: begin
                if (!r_step[0]) begin
                    w_op_a = r_words[0];
                    w_op_b = r_words[4];
                end else begin
                    w_op_a = r_words[8];
                    w_op_b = r_words[12];
                end
            end
        endcase
    end

    assign w_sum = w_op_a + w_op_b;

    // One quarter-round step on column 0
    always_comb begin
        w_qr = r_words;
        case (r_step[1:0])
            2'd0: begin
                w_qr[0]  = w_sum;
                w_qr[12] = ccx_rotl(r_words[12] ^ w_sum, 16);
            end
            2'd1: begin
                w_qr[8]  = w_sum;
                w_qr[4]  = ccx_rotl(r_words[4] ^ w_sum, 12);
            end
            2'd2: begin
                w_qr[0]  = w_sum;
                w_qr[12] = ccx_rotl(r_words[12] ^ w_sum, 8);
            end
            default: begin
                w_qr[8]  = w_sum;
                w_qr[4]  = ccx_rotl(r_words[4] ^ w_sum, 7);
            end
        endcase
    end

    // Bring the next column to column 0 after the last step of a quarter-round;
    // after the fourth one, switch between column and diagonal layout
    assign w_col = ccx_col_shift(w_qr);

    always_comb begin
        if (r_step[1:0] != 2'd3) begin
            w_round_next = w_qr;
        end else if (r_step[3:2] != 2'd3) begin
            w_round_next = w_col;
        end else if (!r_step[4]) begin
            w_round_next = ccx_diag(w_col);
        end else begin
            w_round_next = ccx_undiag(w_col);
        end
    end

    // Feed-forward add: shift words down, sum enters at the top
    always_comb begin
        for (int i = 0; i < 15; i++) begin
            w_fin_next[i] = r_words[i + 1];
        end
        w_fin_next[15] = w_sum;
    end

    // Keystream byte for the current position
    assign w_ks_word  = r_words[r_pos[5:2]];
    assign w_ks_shift = w_ks_word >> {r_pos[1:0], 3'b000};

    // Sequencer
    always_comb begin
        n_state       = r_state;
        n_step        = r_step;
        n_pos         = r_pos;
        n_counter     = r_counter;
        n_block_ready = r_block_ready;
        n_m_valid     = r_m_valid && !m_axis_tready;
        n_m_data      = r_m_data;
        n_m_last      = r_m_last;
        n_hold_byte   = r_hold_byte;
        n_hold_last   = r_hold_last;
        n_words       = r_words;
        case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    n_hold_byte = s_axis_tdata;
                    n_hold_last = s_axis_tlast;
                    if (r_block_ready) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_words = w_init;
                        n_step  = '0;
                        n_state = ST_ROUND;
                    end
                end
            end
            ST_ROUND: begin
                n_words = w_round_next;
                if (r_step == LastRoundStep) begin
                    n_step  = '0;
                    n_state = ST_FINAL;
                end else begin
                    n_step = r_step + 9'd1;
                end
            end
            ST_FINAL: begin
                n_words = w_fin_next;
                if (r_step == LastFinalStep) begin
                    n_block_ready = 1'b1;
                    n_state       = ST_EMIT;
                end else begin
                    n_step = r_step + 9'd1;
                end
            end
            ST_EMIT: begin
                if (w_emit_fire) begin
                    n_m_valid = 1'b1;
                    n_m_data  = r_hold_byte ^ w_ks_shift[7:0];
                    n_m_last  = r_hold_last;
                    n_pos     = r_pos + 6'd1;
                    if (r_pos == 6'd63) begin
                        n_counter     = r_counter + 32'd1;
                        n_block_ready = 1'b0;
                    end
                    if (r_hold_last) begin
                        n_pos         = '0;
                        n_counter     = CounterStart;
                        n_block_ready = 1'b0;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_step        <= '0;
            r_pos         <= '0;
            r_counter     <= CounterStart;
            r_block_ready <= 1'b0;
            r_m_valid     <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_step        <= n_step;
            r_pos         <= n_pos;
            r_counter     <= n_counter;
            r_block_ready <= n_block_ready;
            r_m_valid     <= n_m_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_m_data    <= n_m_data;
        r_m_last    <= n_m_last;
        r_hold_byte <= n_hold_byte;
        r_hold_last <= n_hold_last;
        r_words     <= n_words;
    end

    // A new output transaction only comes from the emit state
    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_valid) |-> $past(r_state == ST_EMIT))
        else $error("output valid raised outside emit");

    // The last round step hands off to the feed-forward pass
    a_rounds_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && r_step == LastRoundStep) |=> (r_state == ST_FINAL))
        else $error("round schedule did not hand off to feed-forward");

    // A byte skips block generation only when a block is ready
    a_hit_needs_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && $past(r_state == ST_IDLE)) |-> r_block_ready)
        else $error("byte emitted without a keystream block");

    // The last byte of a message restarts position and counter
    a_last_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit_fire && r_hold_last) |=>
            (r_pos == 6'd0 && r_counter == CounterStart && !r_block_ready))
        else $error("message end did not restart the keystream");

endmodule

`default_nettype wire
